>>> sv/sfs_pkg.sv
// Shared codes and the key width for the symbol filter sets.
`default_nettype none

package sfs_pkg;

  localparam int KEY_BITS = 64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic SEL_EQUITY = 1'b0;
  localparam logic SEL_OPTION = 1'b1;

endpackage

`default_nettype wire

>>> sv/symbol_filter_sets.sv
// Two associative symbol key sets with insert and lookup commands.
//
// The block holds an equity set and an option set of market symbol keys.
// A command word is taken on in_command, in_table_select and in_symbol_key at
// a rising edge where start is high and busy is low. An insert stores the key
// in the lowest free slot of the chosen set unless it is already present; a
// new key that finds the set full is dropped and flagged. A lookup reports
// membership, and an empty equity set matches every key. The equity set
// compares only the low EQUITY_KEY_BITS bits of the key.
// Each command word gives one result word on out_match and out_dropped,
// marked by out_valid for exactly one cycle, after vld_r and the result registers.
// Every stored entry is compared in parallel against the registered command
// word, so busy stays low and one word can be taken in every cycle; a word
// sees the set as left by every word taken before it.
// The receiver cannot stall the result, so nothing is held back.
// A synchronous reset empties both sets at once and discards any word in
// flight; the stored keys themselves are not cleared.
`default_nettype none

module symbol_filter_sets #(
  parameter int SET_CAPACITY    = 64,
  parameter int EQUITY_KEY_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_command,
  input  wire logic                        in_table_select,
  input  wire logic [sfs_pkg::KEY_BITS-1:0] in_symbol_key,
  output logic                             out_valid,
  output logic                             out_match,
  output logic                             out_dropped
);

  import sfs_pkg::*;

  logic                       vld_r;
  logic                       cmd_r;
  logic                       sel_r;
  logic [KEY_BITS-1:0]        key_r;

  logic [EQUITY_KEY_BITS-1:0] eq_key_r [SET_CAPACITY];
  logic [KEY_BITS-1:0]        op_key_r [SET_CAPACITY];
  logic [SET_CAPACITY-1:0]    eq_valid_r;
  logic [SET_CAPACITY-1:0]    op_valid_r;
  logic [SET_CAPACITY-1:0]    eq_valid_nxt;
  logic [SET_CAPACITY-1:0]    op_valid_nxt;

  logic                       out_valid_r;
  logic                       out_match_r;
  logic                       out_dropped_r;
  logic                       out_match_nxt;
  logic                       out_dropped_nxt;

  logic [EQUITY_KEY_BITS-1:0] key_eq;
  logic [SET_CAPACITY-1:0]    eq_hit;
  logic [SET_CAPACITY-1:0]    op_hit;
  logic [SET_CAPACITY-1:0]    sel_valid;
  logic [SET_CAPACITY-1:0]    free_oh;
  logic                       hit;
  logic                       any;
  logic                       full;
  logic                       do_ins;

  assign busy        = 1'b0;
  assign out_valid   = out_valid_r;
  assign out_match   = out_match_r;
  assign out_dropped = out_dropped_r;

  assign key_eq = key_r[EQUITY_KEY_BITS-1:0];

  always_comb begin
    for (int i = 0; i < SET_CAPACITY; i++) begin
      eq_hit[i] = eq_valid_r[i] && (eq_key_r[i] == key_eq);
      op_hit[i] = op_valid_r[i] && (op_key_r[i] == key_r);
    end
  end

  assign sel_valid = (sel_r == SEL_OPTION) ? op_valid_r : eq_valid_r;
  assign hit       = (sel_r == SEL_OPTION) ? (|op_hit) : (|eq_hit);
  assign any       = |sel_valid;
  assign full      = &sel_valid;
  // The lowest clear bit of the valid vector marks the free slot.
  assign free_oh   = ~sel_valid & (sel_valid + {{(SET_CAPACITY-1){1'b0}}, 1'b1});
  assign do_ins    = vld_r && (cmd_r == CMD_INSERT) && !hit && !full;

  always_comb begin
    eq_valid_nxt = eq_valid_r;
    op_valid_nxt = op_valid_r;
    if (do_ins) begin
      if (sel_r == SEL_OPTION) begin
        op_valid_nxt = op_valid_r | free_oh;
      end else begin
        eq_valid_nxt = eq_valid_r | free_oh;
      end
    end
  end

  always_comb begin
    if (cmd_r == CMD_LOOKUP) begin
      out_match_nxt   = hit || ((sel_r == SEL_EQUITY) && !any);
      out_dropped_nxt = 1'b0;
    end else begin
      out_match_nxt   = hit || !full;
      out_dropped_nxt = !hit && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
      eq_valid_r  <= '0;
      op_valid_r  <= '0;
    end else begin
      vld_r       <= start && !busy;
      out_valid_r <= vld_r;
      eq_valid_r  <= eq_valid_nxt;
      op_valid_r  <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_command;
      sel_r <= in_table_select;
      key_r <= in_symbol_key;
    end
    if (vld_r) begin
      out_match_r   <= out_match_nxt;
      out_dropped_r <= out_dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SET_CAPACITY; i++) begin
      if (do_ins && free_oh[i]) begin
        if (sel_r == SEL_OPTION) begin
          op_key_r[i] <= key_r;
        end else begin
          eq_key_r[i] <= key_eq;
        end
      end
    end
  end

  // A result word never reports both a match and a drop.
  a_match_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_match && out_dropped))
    else $error("result word reports both match and drop");

  // The result strobe follows each accepted command word through vld_r and out_valid_r.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) |-> out_valid == $past(start && !busy, 2))
    else $error("result strobe out of step with accepted words");

  // An insert of a new key into a full set is always reported as a drop.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && (cmd_r == CMD_INSERT) && !hit && full |=> out_dropped)
    else $error("insert into a full set was not flagged");

  // An insert adds at most one entry to each set per cycle.
  a_grow_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(eq_valid_r ^ $past(eq_valid_r)) <= 1) &&
                     ($countones(op_valid_r ^ $past(op_valid_r)) <= 1))
    else $error("set valid bits changed by more than one slot");

  // Entries are never released while out of reset.
  a_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((eq_valid_r & $past(eq_valid_r)) == $past(eq_valid_r)) &&
                     ((op_valid_r & $past(op_valid_r)) == $past(op_valid_r)))
    else $error("a stored entry lost its valid bit");

endmodule

`default_nettype wire
